>>> rtl/sdpr_pkg.sv
package sdpr_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int LANE_W = 8;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LANE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENGINE = 2'd2;

    // Engine state after reset and the fill used to keep seeded words non-zero.
    localparam logic [WORD_W-1:0] JSF_A_INIT   = 32'hf1ea5eed;
    localparam logic [WORD_W-1:0] FILL_NONZERO = 32'd123456789;
    localparam logic [WORD_W-1:0] KISS_X_INIT  = 32'd123456789;
    localparam logic [WORD_W-1:0] KISS_Y_INIT  = 32'd362436000;
    localparam logic [WORD_W-1:0] KISS_Z_INIT  = 32'd521288629;
    localparam logic [WORD_W-1:0] KISS_C_INIT  = 32'd7654321;
    localparam logic [WORD_W-1:0] MWC_MULT     = 32'd698769069;
    localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
    localparam logic [WORD_W-1:0] LCG_ADD      = 32'd12345;

    typedef enum logic [1:0] {
        CMD_RAW     = 2'd0,
        CMD_BOUNDED = 2'd1,
        CMD_RESEED  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    // One classified command waiting between the front and the back.
    typedef struct packed {
        cmd_t              kind;
        logic              inv;   // range_high below range_low
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] diff;  // range_high - range_low, modulo 2^32
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_out_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] remainder;
    } rem_rsp_t;

    typedef struct packed {
        logic div_wait;
    } back_status_t;

    function automatic logic [WORD_W-1:0] nonzero(input logic [WORD_W-1:0] v);
        return (v != '0) ? v : FILL_NONZERO;
    endfunction

endpackage

>>> rtl/sdpr_front.sv
module sdpr_front
    import sdpr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*WORD_W-1:0]   s_tdata,   // range_low, range_high
    input  logic [1:0]            s_tuser,   // command
    output q_out_t                q_out,
    input  logic                  q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t          queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W:0]   diff_w;
    q_entry_t          new_entry;
    logic              push;
    logic              pop;

    // Classify the command: the borrow of the subtraction marks an inverted range.
    always_comb
    begin
        diff_w          = {1'b0, s_tdata[2*WORD_W-1:WORD_W]} - {1'b0, s_tdata[WORD_W-1:0]};
        new_entry.kind  = cmd_t'(s_tuser);
        new_entry.inv   = diff_w[WORD_W];
        new_entry.lo    = s_tdata[WORD_W-1:0];
        new_entry.diff  = diff_w[WORD_W-1:0];
    end

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign q_out.valid = (count_reg != '0);
    assign q_out.entry = queue_reg[rd_ptr_reg];

endmodule

>>> rtl/sdpr_rem.sv
module sdpr_rem
    import sdpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rem_req_t req,
    output rem_rsp_t rsp
);

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W:0]   trial;

    // Restoring remainder, one dividend bit per cycle, most significant first.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[WORD_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = WORD_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> rtl/sdpr_back.sv
module sdpr_back
    import sdpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    input  q_out_t                q_in,
    output logic                  q_pop,
    output rem_req_t              rem_req,
    input  rem_rsp_t              rem_rsp,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WORD_W-1:0]     m_tdata,   // value
    output logic                  m_tuser,   // range_error
    output back_status_t          status
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_KISS_SUM  = 5'b00010,
        ST_KISS_WORD = 5'b00100,
        ST_DIV       = 5'b01000,
        ST_EMIT      = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic              eng_reg, eng_next;

    logic [WORD_W-1:0] jsf_a_reg, jsf_a_next, jsf_b_reg, jsf_b_next;
    logic [WORD_W-1:0] jsf_c_reg, jsf_c_next, jsf_d_reg, jsf_d_next;
    logic [WORD_W-1:0] lcg_reg, lcg_next, xs_reg, xs_next;
    logic [WORD_W-1:0] mwc_reg, mwc_next, carry_reg, carry_next;

    logic [WORD_W-1:0]   lcg_prod_reg, lcg_prod_next;
    logic [2*WORD_W-1:0] mwc_prod_reg, mwc_prod_next;
    logic [WORD_W-1:0]   lo_reg, lo_next;
    logic [WORD_W-1:0]   span_reg, span_next;
    logic                direct_reg, direct_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic                rem_start_reg, rem_start_next;
    logic [WORD_W-1:0]   res_val_reg, res_val_next;
    logic                res_err_reg, res_err_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_data_reg, out_data_next;
    logic                out_err_reg, out_err_next;

    q_entry_t            ent;
    logic                need_draw;
    logic                direct_now;
    logic [WORD_W-1:0]   jsf_e, jsf_na, jsf_nd;
    logic [WORD_W-1:0]   xs1, xs2, xs3;
    logic [WORD_W-1:0]   seed_sum;
    logic [2*WORD_W-1:0] mwc_t;
    logic [WORD_W-1:0]   kiss_word;

    function automatic logic [WORD_W-1:0] rotl27(input logic [WORD_W-1:0] x);
        return {x[4:0], x[31:5]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl17(input logic [WORD_W-1:0] x);
        return {x[14:0], x[31:15]};
    endfunction

    always_comb
    begin
        seed_next = seed_reg;
        lane_next = lane_reg;
        eng_next  = eng_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEED:   seed_next = cfg_data;
                REG_LANE:   lane_next = cfg_data[LANE_W-1:0];
                REG_ENGINE: eng_next  = cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        ent        = q_in.entry;
        need_draw  = (ent.kind == CMD_RAW) || ((ent.kind == CMD_BOUNDED) && !ent.inv);
        direct_now = (ent.kind == CMD_RAW) || (ent.diff == '1);
        jsf_e      = jsf_a_reg - rotl27(jsf_b_reg);
        jsf_na     = jsf_b_reg ^ rotl17(jsf_c_reg);
        jsf_nd     = jsf_e + jsf_na;
        xs1        = xs_reg ^ {xs_reg[WORD_W-14:0], 13'b0};
        xs2        = xs1 ^ {17'b0, xs1[WORD_W-1:17]};
        xs3        = xs2 ^ {xs2[WORD_W-6:0], 5'b0};
        seed_sum   = seed_reg + {{(WORD_W-LANE_W){1'b0}}, lane_reg};
        mwc_t      = mwc_prod_reg + {{WORD_W{1'b0}}, carry_reg};
        kiss_word  = lcg_reg + xs_reg + mwc_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        jsf_a_next     = jsf_a_reg;
        jsf_b_next     = jsf_b_reg;
        jsf_c_next     = jsf_c_reg;
        jsf_d_next     = jsf_d_reg;
        lcg_next       = lcg_reg;
        xs_next        = xs_reg;
        mwc_next       = mwc_reg;
        carry_next     = carry_reg;
        lcg_prod_next  = lcg_prod_reg;
        mwc_prod_next  = mwc_prod_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        direct_next    = direct_reg;
        word_next      = word_reg;
        rem_start_next = 1'b0;
        res_val_next   = res_val_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    q_pop       = 1'b1;
                    lo_next     = ent.lo;
                    span_next   = ent.diff + 1'b1;
                    direct_next = direct_now;
                    if (need_draw)
                    begin
                        if (eng_reg)
                        begin
                            xs_next       = xs3;
                            lcg_prod_next = lcg_reg * LCG_MULT;
                            mwc_prod_next = {{WORD_W{1'b0}}, mwc_reg} *
                                            {{WORD_W{1'b0}}, MWC_MULT};
                            state_next    = ST_KISS_SUM;
                        end
                        else
                        begin
                            jsf_a_next = jsf_na;
                            jsf_b_next = jsf_c_reg + jsf_d_reg;
                            jsf_c_next = jsf_d_reg + jsf_e;
                            jsf_d_next = jsf_nd;
                            if (direct_now)
                            begin
                                res_val_next = jsf_nd;
                                res_err_next = 1'b0;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                word_next      = jsf_nd;
                                rem_start_next = 1'b1;
                                state_next     = ST_DIV;
                            end
                        end
                    end
                    else
                    begin
                        res_val_next = '0;
                        res_err_next = 1'b0;
                        if (ent.kind == CMD_BOUNDED)
                        begin
                            res_val_next = ent.lo;
                            res_err_next = 1'b1;
                        end
                        else if (ent.kind == CMD_RESEED)
                        begin
                            lcg_next   = nonzero(seed_sum + KISS_X_INIT);
                            xs_next    = nonzero(seed_sum + KISS_Y_INIT);
                            mwc_next   = nonzero(seed_sum + KISS_Z_INIT);
                            carry_next = nonzero(seed_sum + KISS_C_INIT);
                            jsf_a_next = JSF_A_INIT;
                            jsf_b_next = nonzero(seed_sum);
                            jsf_c_next = nonzero(seed_sum);
                            jsf_d_next = seed_sum;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_KISS_SUM:
            begin
                lcg_next   = lcg_prod_reg + LCG_ADD;
                mwc_next   = mwc_t[WORD_W-1:0];
                carry_next = mwc_t[2*WORD_W-1:WORD_W];
                state_next = ST_KISS_WORD;
            end

            ST_KISS_WORD:
            begin
                if (direct_reg)
                begin
                    res_val_next = kiss_word;
                    res_err_next = 1'b0;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    word_next      = kiss_word;
                    rem_start_next = 1'b1;
                    state_next     = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (rem_rsp.done)
                begin
                    res_val_next = rem_rsp.remainder + lo_reg;
                    res_err_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_val_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            lane_reg      <= '0;
            eng_reg       <= 1'b0;
            jsf_a_reg     <= JSF_A_INIT;
            jsf_b_reg     <= FILL_NONZERO;
            jsf_c_reg     <= FILL_NONZERO;
            jsf_d_reg     <= '0;
            lcg_reg       <= KISS_X_INIT;
            xs_reg        <= KISS_Y_INIT;
            mwc_reg       <= KISS_Z_INIT;
            carry_reg     <= KISS_C_INIT;
            rem_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            lane_reg      <= lane_next;
            eng_reg       <= eng_next;
            jsf_a_reg     <= jsf_a_next;
            jsf_b_reg     <= jsf_b_next;
            jsf_c_reg     <= jsf_c_next;
            jsf_d_reg     <= jsf_d_next;
            lcg_reg       <= lcg_next;
            xs_reg        <= xs_next;
            mwc_reg       <= mwc_next;
            carry_reg     <= carry_next;
            rem_start_reg <= rem_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lcg_prod_reg <= lcg_prod_next;
        mwc_prod_reg <= mwc_prod_next;
        lo_reg       <= lo_next;
        span_reg     <= span_next;
        direct_reg   <= direct_next;
        word_reg     <= word_next;
        res_val_reg  <= res_val_next;
        res_err_reg  <= res_err_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign rem_req.start    = rem_start_reg;
    assign rem_req.dividend = word_reg;
    assign rem_req.divisor  = span_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    assign status.div_wait = (state_reg == ST_DIV);

endmodule

>>> rtl/seeded_dual_prng_with_range_unit.sv
// Seeded dual-engine 32-bit pseudo-random generator with a range unit.
//
// Commands arrive on the slave stream: s_tuser carries the command (raw draw,
// bounded draw, reseed) and s_tdata carries range_low and range_high. Every
// command yields exactly one result transaction on the master stream, with
// the value in m_tdata and the range error flag in m_tuser.
// Configuration (seed, lane_index, engine_select) is written through a plain
// write port: cfg_we, cfg_index and cfg_data, with no read-back.
//
// A front stage classifies each command and parks it in a small queue, so new
// transactions are taken while the back end is busy or the receiver stalls.
// The back end works on one command at a time. A raw draw on the Jenkins
// engine goes from the queue through the emit state to the output register;
// the KISS engine first adds its registered multiply and sum. A bounded draw
// short of the full span also runs the restoring remainder unit, one bit per
// cycle. Reseeds, inverted ranges and unused commands go straight to emit.
//
// Reset loads both engines with their fixed start state and clears the
// configuration to zero. A result waits in the output register while
// m_tready is low; the queue then fills and s_tready drops.
module seeded_dual_prng_with_range_unit
    import sdpr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*WORD_W-1:0]   s_tdata,   // range_low, range_high
    input  logic [1:0]            s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WORD_W-1:0]     m_tdata,   // value
    output logic                  m_tuser,   // range_error
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    q_out_t       q_out;
    logic         q_pop;
    rem_req_t     rem_req;
    rem_rsp_t     rem_rsp;
    back_status_t back_status;

    // Front end: classification and the command queue.
    sdpr_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_out    (q_out),
        .q_pop    (q_pop)
    );

    // Iterative remainder for the modulo of a bounded draw.
    sdpr_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // Back end: both engines, the reseed logic and the output register.
    sdpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_in      (q_out),
        .q_pop     (q_pop),
        .rem_req   (rem_req),
        .rem_rsp   (rem_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .status    (back_status)
    );

    // The back end only takes a command that the queue actually holds.
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_out.valid)
        else $error("command taken from an empty queue");

    // A finished remainder is only ever delivered to a waiting back end.
    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.done |-> back_status.div_wait)
        else $error("remainder finished while the back end was not waiting");

    // The remainder unit starts only on a request from the back end.
    a_rem_started: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rem_rsp.busy) |-> $past(rem_req.start))
        else $error("remainder unit started without a request");

    // While a remainder runs, the back end stays in its wait state.
    a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.busy |-> back_status.div_wait)
        else $error("back end left its wait state during a remainder");

endmodule

>>> verif/seeded_dual_prng_checker.sv
`timescale 1ns / 100ps

module seeded_dual_prng_checker
    import sdpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [2*WORD_W-1:0]  s_tdata,   // range_low, range_high
    input  logic [1:0]           s_tuser,   // command
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [WORD_W-1:0]    m_tdata,   // value
    input  logic                 m_tuser,   // range_error
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output int                   mismatch_count,
    output int                   outstanding,
    output int                   results_seen
);

    typedef struct {
        logic [WORD_W-1:0] value;
        logic              range_error;
    } outcome_t;

    // Outcomes of accepted commands, oldest first.
    outcome_t awaited_outcomes[$];
    outcome_t oldest;

    logic [WORD_W-1:0] seed_reg;
    logic [LANE_W-1:0] lane_reg;
    logic              engine_reg;

    // Jenkins small fast words and the three KISS parts.
    logic [WORD_W-1:0] sf_a, sf_b, sf_c, sf_d;
    logic [WORD_W-1:0] lcg_word, xs_word, mwc_word, mwc_carry;

    int mismatches = 0;
    int checked = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [WORD_W-1:0] next_small_fast();
        logic [WORD_W-1:0] e;
        e    = sf_a - {sf_b[4:0], sf_b[WORD_W-1:5]};
        sf_a = sf_b ^ {sf_c[14:0], sf_c[WORD_W-1:15]};
        sf_b = sf_c + sf_d;
        sf_c = sf_d + e;
        sf_d = e + sf_a;
        return sf_d;
    endfunction

    function automatic logic [WORD_W-1:0] next_kiss();
        logic [2*WORD_W-1:0] product;
        lcg_word = LCG_MULT * lcg_word + LCG_ADD;
        xs_word ^= xs_word << 13;
        xs_word ^= xs_word >> 17;
        xs_word ^= xs_word << 5;
        product = {{WORD_W{1'b0}}, MWC_MULT} * {{WORD_W{1'b0}}, mwc_word}
                + {{WORD_W{1'b0}}, mwc_carry};
        mwc_carry = product[2*WORD_W-1:WORD_W];
        mwc_word  = product[WORD_W-1:0];
        return lcg_word + xs_word + mwc_word;
    endfunction

    function automatic logic [WORD_W-1:0] next_word();
        return engine_reg ? next_kiss() : next_small_fast();
    endfunction

    function automatic logic [WORD_W-1:0] fill_if_zero(input logic [WORD_W-1:0] v);
        return (v == '0) ? FILL_NONZERO : v;
    endfunction

    function automatic void reload_engines();
        logic [WORD_W-1:0] s;
        s = seed_reg + {{(WORD_W-LANE_W){1'b0}}, lane_reg};
        lcg_word  = fill_if_zero(s + KISS_X_INIT);
        xs_word   = fill_if_zero(s + KISS_Y_INIT);
        mwc_word  = fill_if_zero(s + KISS_Z_INIT);
        mwc_carry = fill_if_zero(s + KISS_C_INIT);
        sf_a = JSF_A_INIT;
        sf_b = s;
        sf_c = s;
        sf_d = s;
        if (s == '0) begin
            sf_b = FILL_NONZERO;
            sf_c = FILL_NONZERO;
        end
    endfunction

    function automatic outcome_t resolve_command(input cmd_t cmd,
                                                 input logic [WORD_W-1:0] lo,
                                                 input logic [WORD_W-1:0] hi);
        outcome_t            r;
        logic [2*WORD_W-1:0] span;
        logic [2*WORD_W-1:0] word;
        logic [2*WORD_W-1:0] rem;
        r.value       = '0;
        r.range_error = 1'b0;
        case (cmd)
            CMD_RAW: r.value = next_word();
            CMD_BOUNDED: begin
                if (hi < lo) begin
                    // An inverted range leaves both engines where they are.
                    r.value       = lo;
                    r.range_error = 1'b1;
                end else begin
                    span = {{WORD_W{1'b0}}, hi} - {{WORD_W{1'b0}}, lo} + 1;
                    word = {{WORD_W{1'b0}}, next_word()};
                    if (span[WORD_W]) begin
                        r.value = word[WORD_W-1:0];
                    end else begin
                        rem     = word % span;
                        r.value = rem[WORD_W-1:0] + lo;
                    end
                end
            end
            CMD_RESEED: reload_engines();
            CMD_NOP: ;
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seed_reg   = '0;
            lane_reg   = '0;
            engine_reg = 1'b0;
            sf_a       = JSF_A_INIT;
            sf_b       = 32'd123456789;
            sf_c       = 32'd123456789;
            sf_d       = '0;
            lcg_word   = KISS_X_INIT;
            xs_word    = KISS_Y_INIT;
            mwc_word   = KISS_Z_INIT;
            mwc_carry  = KISS_C_INIT;
            awaited_outcomes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SEED:   seed_reg = cfg_data;
                    REG_LANE:   lane_reg = cfg_data[LANE_W-1:0];
                    REG_ENGINE: engine_reg = cfg_data[0];
                    default: ;
                endcase
            end
            // Results are matched before this edge's command is queued, so a
            // stray result can never pair with a command taken in the same cycle.
            if (m_tvalid && m_tready) begin
                checked++;
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result value %h error %b with no command waiting",
                                              m_tdata, m_tuser));
                end else begin
                    oldest = awaited_outcomes.pop_front();
                    if (m_tdata !== oldest.value)
                        report_mismatch($sformatf("value %h, predicted %h",
                                                  m_tdata, oldest.value));
                    if (m_tuser !== oldest.range_error)
                        report_mismatch($sformatf("range_error %b, predicted %b",
                                                  m_tuser, oldest.range_error));
                end
            end
            if (s_tvalid && s_tready)
                awaited_outcomes.push_back(resolve_command(cmd_t'(s_tuser),
                                                           s_tdata[WORD_W-1:0],
                                                           s_tdata[2*WORD_W-1:WORD_W]));
        end
        outstanding    <= awaited_outcomes.size();
        mismatch_count <= mismatches;
        results_seen   <= checked;
    end

endmodule

>>> verif/tb_seeded_dual_prng_with_range_unit.sv
`timescale 1ns / 100ps

// Top of the random generator testbench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts every result and
// compares it.
module tb_seeded_dual_prng_with_range_unit;
    import sdpr_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [2*WORD_W-1:0]  s_tdata;   // range_low, range_high
    logic [1:0]           s_tuser;   // command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [WORD_W-1:0]    m_tdata;   // value
    logic                 m_tuser;   // range_error
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    int mismatches;
    int pending;
    int results_seen;

    // Bookkeeping for the sender and for the closing summary.
    int burst_left = 0;
    int kind_count[4] = '{0, 0, 0, 0};
    int inverted_count = 0;
    int settings_applied = 0;
    int long_holds = 0;
    bit random_phase = 1'b0;

    seeded_dual_prng_with_range_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    seeded_dual_prng_checker result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .outstanding    (pending),
        .results_seen   (results_seen)
    );

    // 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offers one command and returns at the falling edge after the transaction.
    // The sender works in bursts: when a burst runs out, tvalid drops for a
    // random gap (sometimes none) and the data lines carry junk meanwhile.
    // tvalid is left high on return so that back-to-back commands stay
    // back-to-back; anything that pauses the sender lowers it first.
    task automatic send_command(input cmd_t cmd, input logic [WORD_W-1:0] lo,
                                input logic [WORD_W-1:0] hi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= {$urandom, $urandom};
                s_tuser  <= 2'($urandom_range(0, 3));
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tuser  <= cmd;
        s_tdata  <= {hi, lo};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        kind_count[cmd]++;
        if (cmd == CMD_BOUNDED && hi < lo)
            inverted_count++;
    endtask

    // Stops offering and waits until every result is back. Each command yields
    // one result, but the pause after it covers the longest bounded draw in
    // case the block is still settling.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(negedge clk);
    endtask

    // Writes all three registers on consecutive cycles. Only called while idle.
    task automatic apply_settings(input logic [WORD_W-1:0] seed,
                                  input logic [LANE_W-1:0] lane, input logic engine);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SEED;
        cfg_data  <= seed;
        @(negedge clk);
        cfg_index <= REG_LANE;
        cfg_data  <= {{(WORD_W-LANE_W){1'b0}}, lane};
        @(negedge clk);
        cfg_index <= REG_ENGINE;
        cfg_data  <= {{(WORD_W-1){1'b0}}, engine};
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(negedge clk);
        settings_applied++;
    endtask

    // Random command mix. Bounded draws dominate and come in several range
    // shapes: narrow spans (which may wrap past the top into an inverted
    // range), fully random bounds (about half inverted), the full 32-bit span,
    // single values, power-of-two spans and spans just short of full.
    task automatic pick_command(output cmd_t cmd, output logic [WORD_W-1:0] lo,
                                output logic [WORD_W-1:0] hi);
        int roll;
        int k;
        roll = $urandom_range(0, 99);
        lo = $urandom;
        hi = $urandom;
        if (roll < 30) begin
            cmd = CMD_RAW;
        end else if (roll < 85) begin
            cmd = CMD_BOUNDED;
            case ($urandom_range(0, 5))
                0: hi = lo + $urandom_range(0, 15);
                1: ;
                2: begin
                    lo = '0;
                    hi = '1;
                end
                3: hi = lo;
                4: begin
                    k = $urandom_range(1, 31);
                    hi = lo + ((32'd1 << k) - 1);
                end
                default: begin
                    lo = $urandom_range(0, 255);
                    hi = 32'hffff_ffff - $urandom_range(0, 255);
                end
            endcase
        end else if (roll < 93) begin
            cmd = CMD_RESEED;
        end else begin
            cmd = CMD_NOP;
        end
    endtask

    initial
    begin : stimulus
        cmd_t              cmd;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] seed;
        logic [LANE_W-1:0] lane;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_RAW;
        cfg_we    = 1'b0;
        cfg_index = REG_SEED;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, first on the reset configuration (Jenkins engine,
        // seed and lane zero): range extremes, both kinds of inverted range,
        // the full span, the unused command and a reseed from a zero sum.
        send_command(CMD_RAW,     32'hffff_ffff, 32'h0000_0000);
        send_command(CMD_BOUNDED, 32'h0000_0000, 32'h0000_0000);
        send_command(CMD_BOUNDED, 32'h0000_0000, 32'hffff_ffff);
        send_command(CMD_BOUNDED, 32'hffff_ffff, 32'hffff_ffff);
        send_command(CMD_BOUNDED, 32'h0000_0001, 32'hffff_ffff);
        send_command(CMD_BOUNDED, 32'd100,       32'd199);
        send_command(CMD_BOUNDED, 32'd5,         32'd4);
        send_command(CMD_BOUNDED, 32'hffff_ffff, 32'h0000_0000);
        send_command(CMD_NOP,     32'h1234_5678, 32'h9abc_def0);
        send_command(CMD_RESEED,  32'h0000_0000, 32'h0000_0000);
        send_command(CMD_RAW,     32'h0000_0000, 32'hffff_ffff);

        // KISS engine with seed plus lane wrapping to zero.
        drain_results();
        apply_settings(32'hffff_ffff, 8'd1, 1'b1);
        send_command(CMD_RAW,     32'h5555_5555, 32'haaaa_aaaa);
        send_command(CMD_BOUNDED, 32'h0000_0000, 32'hffff_ffff);
        send_command(CMD_BOUNDED, 32'd7,         32'd3);
        send_command(CMD_BOUNDED, 32'd0,         32'd9);
        send_command(CMD_RESEED,  32'hffff_ffff, 32'hffff_ffff);
        send_command(CMD_RAW,     32'h0000_0000, 32'h0000_0000);
        send_command(CMD_NOP,     32'h0000_0000, 32'h0000_0000);

        // A seed whose LCG start word sums to zero and must be forced non-zero.
        drain_results();
        apply_settings(32'hf8a4_32eb, 8'd0, 1'b1);
        send_command(CMD_RESEED,  32'h0000_0000, 32'h0000_0000);
        send_command(CMD_RAW,     32'h0000_0000, 32'h0000_0000);
        send_command(CMD_BOUNDED, 32'd0,         32'd1);

        // Largest seed and lane back on the Jenkins engine.
        drain_results();
        apply_settings(32'hffff_ffff, 8'hff, 1'b0);
        send_command(CMD_RESEED,  32'h0000_0000, 32'h0000_0000);
        send_command(CMD_RAW,     32'h0000_0000, 32'h0000_0000);
        send_command(CMD_BOUNDED, 32'h0000_0000, 32'hffff_fffe);

        // Random part: five settings of 130 commands each, alternating engines,
        // with seed and lane sometimes at their extremes.
        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            case ($urandom_range(0, 3))
                0:       seed = '0;
                1:       seed = '1;
                default: seed = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       lane = '0;
                1:       lane = '1;
                default: lane = $urandom_range(0, 255);
            endcase
            apply_settings(seed, lane, phase[0]);
            random_phase = 1'b1;
            for (int n = 0; n < 130; n++) begin
                pick_command(cmd, lo, hi);
                send_command(cmd, lo, hi);
            end
        end

        // Let everything come back, then allow some quiet cycles so that any
        // stray extra result still gets caught.
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (50) @(posedge clk);

        $display("Covered %0d commands: %0d raw, %0d bounded (%0d inverted),",
                 kind_count[CMD_RAW] + kind_count[CMD_BOUNDED] + kind_count[CMD_RESEED]
                 + kind_count[CMD_NOP], kind_count[CMD_RAW], kind_count[CMD_BOUNDED],
                 inverted_count);
        $display("%0d reseed, %0d unused; %0d results compared under %0d register settings,",
                 kind_count[CMD_RESEED], kind_count[CMD_NOP], results_seen,
                 settings_applied + 1);
        $display("%0d long output stalls.", long_holds);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // The receiver stalls on its own pattern, which it redraws periodically:
    // always ready, mostly ready, coin flip, or a fixed duty cycle. Once the
    // random part starts it also holds m_tready low for long stalls, up to four
    // of them, while the sender keeps offering, so the queue inside the block
    // fills up and s_tready drops.
    initial
    begin : receiver
        int cycle;
        int mode;
        int hold_left;

        cycle = 0;
        mode = 0;
        hold_left = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            cycle++;
            if (cycle % 64 == 0)
                mode = $urandom_range(0, 3);
            if (random_phase && hold_left == 0 && long_holds < 4
                && (long_holds == 0 || cycle % 3000 == 0)) begin
                hold_left = 300;
                long_holds++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (cycle % 7 < 3);
                endcase
            end
        end
    end

    // Far beyond the slowest correct run.
    initial
    begin : watchdog
        #6_000_000;
        $display("Timeout: %0d results still outstanding.", pending);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
